// ===== design/nmea_gga_rmc_time_sat_parser_macros.svh =====
// Assertion macros for the NMEA time and satellite parser.
// Used by the top level; expects clk and rst_n in scope.
`ifndef NMEA_GGA_RMC_TIME_SAT_PARSER_MACROS_SVH
`define NMEA_GGA_RMC_TIME_SAT_PARSER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define NGR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define NGR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ngr_pkg.sv =====
// Shared types, constants and helpers for the NMEA time and satellite parser.
// No dependencies.
package ngr_pkg;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_GGA  = 2'd1,
    KIND_RMC  = 2'd2,
    KIND_BOTH = 2'd3
  } line_kind_t;

  localparam logic [2:0] HDR_LEN    = 3'd6;
  localparam logic [2:0] BUF_DEPTH  = 3'd6;
  localparam logic [3:0] CNT_MAX    = 4'd15;
  localparam logic [4:0] FIELD_NONE = 5'd31;
  localparam logic [4:0] FIELD_SATS = 5'd7;
  localparam logic [4:0] FIELD_TIME = 5'd1;
  localparam logic [4:0] FIELD_DATE = 5'd9;

  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  localparam logic [7:0] RST_YEAR   = 8'd18;
  localparam logic [7:0] RST_MONTH  = 8'd6;
  localparam logic [7:0] RST_DAY    = 8'd1;
  localparam logic [7:0] RST_HOUR   = 8'd18;
  localparam logic [7:0] RST_MINUTE = 8'd30;
  localparam logic [7:0] RST_SECOND = 8'd0;
  localparam logic [7:0] RST_PREV_SATS = 8'hFF;

  typedef struct packed {
    logic [7:0] char_in;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0] sentence_kind;
    logic [7:0] satellites;
    logic       satellites_new;
    logic       time_update;
    logic [7:0] hour;
    logic [7:0] minute;
    logic [7:0] second;
    logic [7:0] day;
    logic [7:0] month;
    logic [7:0] year;
  } out_item_t;

  // load strobe and payload handed to the output register
  typedef struct packed {
    logic      load;
    out_item_t item;
  } res_load_t;

  function automatic logic [7:0] hdr_gga_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0: c = "$";
      3'd1: c = "G";
      3'd2: c = "N";
      3'd3: c = "G";
      3'd4: c = "G";
      3'd5: c = "A";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] hdr_rmc_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0: c = "$";
      3'd1: c = "G";
      3'd2: c = "N";
      3'd3: c = "R";
      3'd4: c = "M";
      3'd5: c = "C";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // (hi-'0')*10 + (lo-'0'), all mod 256
  function automatic logic [7:0] pair_value(input logic [7:0] hi, input logic [7:0] lo);
    logic [7:0] h;
    logic [7:0] l;
    h = hi - CHAR_ZERO;
    l = lo - CHAR_ZERO;
    return {h[4:0], 3'b000} + {h[6:0], 1'b0} + l;
  endfunction

endpackage

// ===== design/nmea_gga_rmc_time_sat_parser.sv =====
// NMEA GGA/RMC parser, top level: input register, parse core, result register.
// Depends on ngr_pkg, ngr_parse_core, ngr_out_stage and the assertion macros header.
//
// Takes one character of an NMEA sentence line per item (char_in, with line_end on the
// last character) and, on each line end, returns one result item carrying the sentence
// kind ($GNGGA, $GNRMC or other), the latest satellite count with its changed-since-
// last-report flag, the stored hour/minute/second/day/month/year, and time_update when
// an RMC line carried both time and date. Lines without line_end produce no result.
// Rate: one item per cycle while the result register is not stalled. A line-end item
// passes the input register, then the character update into the result register.
// The only stall source is the result register: when a result is held and out_ready
// is low, the parse core stops and the input register fills, then in_ready drops.
// Fields are located by comma count; only the first six characters of a field are
// kept, an asterisk ends field parsing for the rest of the line, and digit pairs are
// evaluated in 8-bit wraparound arithmetic. No configuration, no clearing pass: after
// reset the block is ready at once.
`include "nmea_gga_rmc_time_sat_parser_macros.svh"

module nmea_gga_rmc_time_sat_parser
  import ngr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // input register
  logic     s1_valid_r, s1_valid_nxt;
  in_item_t s1_data_r;

  logic      can_load;  // result register can take a result this cycle
  logic      step;      // core consumes the held character
  res_load_t core_res;
  res_load_t load_req;

  assign step     = s1_valid_r && can_load;
  assign in_ready = !s1_valid_r || can_load;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (step) s1_valid_nxt = 1'b0;
    if (in_valid && in_ready) s1_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
  end

  ngr_parse_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step),
    .item    (s1_data_r),
    .res     (core_res)
  );

  // only a stepped line-end character loads a result
  always_comb begin
    load_req      = core_res;
    load_req.load = core_res.load && step;
  end

  ngr_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (load_req),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // a processed line end always shows up as a result next cycle
  `NGR_ASSERT_NEXT(a_line_end_result, step && s1_data_r.line_end, out_valid, "line end lost")
  // input side only backs up behind a stalled result
  `NGR_ASSERT_NOW(a_stall_cause, !in_ready, s1_valid_r && out_valid && !out_ready, "bad stall")
  // time update only reported on a recognized RMC line
  `NGR_ASSERT_NOW(a_time_rmc, out_valid && out_data.time_update,
                  out_data.sentence_kind == KIND_RMC, "time_update on non-RMC line")

endmodule

// ===== design/ngr_parse_core.sv =====
// Per-character parse state and update logic for the NMEA parser.
// Depends on ngr_pkg.
module ngr_parse_core
  import ngr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step_en,
  input  in_item_t  item,
  output res_load_t res
);

  logic [2:0]      hdr_pos_r, hdr_pos_nxt;
  line_kind_t      kind_r, kind_nxt;
  logic [4:0]      field_r, field_nxt;
  logic [3:0]      cnt_r, cnt_nxt;
  logic [5:0][7:0] buf_r, buf_nxt;
  logic            time_seen_r, time_seen_nxt;
  logic            date_seen_r, date_seen_nxt;
  logic            count_seen_r, count_seen_nxt;
  logic [7:0]      sats_r, sats_nxt;
  logic [7:0]      prev_sats_r, prev_sats_nxt;
  logic            pending_r, pending_nxt;
  logic [7:0]      hour_r, hour_nxt, minute_r, minute_nxt, second_r, second_nxt;
  logic [7:0]      day_r, day_nxt, month_r, month_nxt, year_r, year_nxt;

  always_comb begin
    logic            hdr_phase;
    logic [1:0]      match_kind;
    logic            field_act;
    logic            is_sep;
    logic            ordinary;
    logic [3:0]      cntw;
    logic [5:0][7:0] bufw;
    logic            close_en;
    logic            close_hit;
    logic [7:0]      p0, p1, p2;
    logic            active;
    logic [7:0]      c;

    c          = item.char_in;
    hdr_phase  = hdr_pos_r < HDR_LEN;
    match_kind = (hdr_pos_r == 3'd0) ? 2'b11 : kind_r;
    field_act  = !hdr_phase && (kind_r == KIND_GGA || kind_r == KIND_RMC)
                 && (field_r != FIELD_NONE);
    is_sep     = (c == CHAR_COMMA) || (c == CHAR_STAR);
    ordinary   = field_act && !is_sep;

    cntw = cnt_r;
    bufw = buf_r;
    if (ordinary) begin
      if (cnt_r < CNT_MAX) cntw = cnt_r + 4'd1;
      if (cnt_r < {1'b0, BUF_DEPTH}) bufw[cnt_r[2:0]] = c;
    end

    // one close at most per item: a separator, or the end of the line
    close_en  = field_act && (is_sep || item.line_end);
    close_hit = close_en && (cntw != 4'd0);
    p0 = pair_value(bufw[0], bufw[1]);
    p1 = pair_value(bufw[2], bufw[3]);
    p2 = pair_value(bufw[4], bufw[5]);

    hdr_pos_nxt    = hdr_pos_r;
    kind_nxt       = kind_r;
    field_nxt      = field_r;
    cnt_nxt        = cntw;
    buf_nxt        = bufw;
    time_seen_nxt  = time_seen_r;
    date_seen_nxt  = date_seen_r;
    count_seen_nxt = count_seen_r;
    sats_nxt       = sats_r;
    prev_sats_nxt  = prev_sats_r;
    pending_nxt    = pending_r;
    hour_nxt       = hour_r;
    minute_nxt     = minute_r;
    second_nxt     = second_r;
    day_nxt        = day_r;
    month_nxt      = month_r;
    year_nxt       = year_r;

    if (hdr_phase) begin
      hdr_pos_nxt = hdr_pos_r + 3'd1;
      kind_nxt = line_kind_t'({match_kind[1] && (c == hdr_rmc_char(hdr_pos_r)),
                               match_kind[0] && (c == hdr_gga_char(hdr_pos_r))});
    end

    if (field_act && c == CHAR_COMMA && field_r < FIELD_NONE) field_nxt = field_r + 5'd1;
    if (field_act && c == CHAR_STAR) field_nxt = FIELD_NONE;

    if (close_hit) begin
      if (kind_r == KIND_GGA && field_r == FIELD_SATS) begin
        count_seen_nxt = 1'b1;
        sats_nxt = p0;
        if (prev_sats_r != p0) begin
          prev_sats_nxt = p0;
          pending_nxt   = 1'b1;
        end
      end else if (kind_r == KIND_RMC && field_r == FIELD_TIME) begin
        time_seen_nxt = 1'b1;
        hour_nxt      = p0;
        minute_nxt    = p1;
        second_nxt    = p2;
      end else if (kind_r == KIND_RMC && field_r == FIELD_DATE) begin
        date_seen_nxt = 1'b1;
        day_nxt       = p0;
        month_nxt     = p1;
        year_nxt      = p2;
      end
    end
    if (close_en) begin
      cnt_nxt = 4'd0;
      buf_nxt = '0;
    end

    active = (hdr_pos_nxt == HDR_LEN) && (kind_nxt == KIND_GGA || kind_nxt == KIND_RMC);
    res.load                = item.line_end;
    res.item.sentence_kind  = active ? kind_nxt : KIND_NONE;
    res.item.satellites     = sats_nxt;
    res.item.satellites_new = pending_nxt;
    res.item.time_update    = active && kind_nxt == KIND_RMC && time_seen_nxt && date_seen_nxt;
    res.item.hour           = hour_nxt;
    res.item.minute         = minute_nxt;
    res.item.second         = second_nxt;
    res.item.day            = day_nxt;
    res.item.month          = month_nxt;
    res.item.year           = year_nxt;

    // end of line: report, then start the next line clean
    if (item.line_end) begin
      pending_nxt    = 1'b0;
      hdr_pos_nxt    = 3'd0;
      kind_nxt       = KIND_NONE;
      field_nxt      = 5'd0;
      time_seen_nxt  = 1'b0;
      date_seen_nxt  = 1'b0;
      count_seen_nxt = 1'b0;
      cnt_nxt        = 4'd0;
      buf_nxt        = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_pos_r    <= 3'd0;
      kind_r       <= KIND_NONE;
      field_r      <= 5'd0;
      cnt_r        <= 4'd0;
      buf_r        <= '0;
      time_seen_r  <= 1'b0;
      date_seen_r  <= 1'b0;
      count_seen_r <= 1'b0;
      sats_r       <= 8'd0;
      prev_sats_r  <= RST_PREV_SATS;
      pending_r    <= 1'b1;
      hour_r       <= RST_HOUR;
      minute_r     <= RST_MINUTE;
      second_r     <= RST_SECOND;
      day_r        <= RST_DAY;
      month_r      <= RST_MONTH;
      year_r       <= RST_YEAR;
    end else if (step_en) begin
      hdr_pos_r    <= hdr_pos_nxt;
      kind_r       <= kind_nxt;
      field_r      <= field_nxt;
      cnt_r        <= cnt_nxt;
      buf_r        <= buf_nxt;
      time_seen_r  <= time_seen_nxt;
      date_seen_r  <= date_seen_nxt;
      count_seen_r <= count_seen_nxt;
      sats_r       <= sats_nxt;
      prev_sats_r  <= prev_sats_nxt;
      pending_r    <= pending_nxt;
      hour_r       <= hour_nxt;
      minute_r     <= minute_nxt;
      second_r     <= second_nxt;
      day_r        <= day_nxt;
      month_r      <= month_nxt;
      year_r       <= year_nxt;
    end
  end

endmodule

// ===== design/ngr_out_stage.sv =====
// Result register with valid/ready handshake for the NMEA parser.
// Depends on ngr_pkg.
module ngr_out_stage
  import ngr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  res_load_t res,
  output logic      can_load,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      valid_r, valid_nxt;
  out_item_t data_r;

  assign can_load = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (out_ready) valid_nxt = 1'b0;
    if (res.load && can_load) valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load && can_load) begin
      data_r <= res.item;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule
